/* hdl/deq_pkg.sv */
// Shared types, constants and helpers of the double-ended queue.
`default_nettype none

package deq_pkg;

   localparam int CAPACITY   = 1024;
   localparam int DATA_WIDTH = 32;

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   // fixed field widths of the item formats
   localparam int OP_FIELD_W    = 3;
   localparam int VALUE_FIELD_W = 32;
   localparam int POS_FIELD_W   = 10;
   localparam int COUNT_FIELD_W = 11;
   localparam int STAT_FIELD_W  = 2;

   // wide enough for a ring index plus a count or a position, no overflow
   localparam int SUM_W = ((COUNT_W > POS_FIELD_W) ? COUNT_W : POS_FIELD_W) + 1;

   typedef enum logic [OP_FIELD_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ       = 3'd4
   } op_type;

   typedef enum logic [STAT_FIELD_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } deq_cmd_type;

   // ring index + offset, folded back once into the ring
   function automatic logic [ADDR_W-1:0] wrap_slot(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] folded;
      folded = (v >= SUM_W'(CAPACITY)) ? v - SUM_W'(CAPACITY) : v;
      return folded[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/deq_ctrl.sv */
// Sequencer of the double-ended queue: handshakes and datapath commands.
`default_nettype none

module deq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output deq_pkg::deq_cmd_type     cmd
);

   import deq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_ACCESS  = 4'b0010,
      ST_LOAD    = 4'b0100,
      ST_RESPOND = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cmd.execute = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/deq_dpath.sv */
// Datapath of the double-ended queue: ring store, pointers and result registers.
`default_nettype none

module deq_dpath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire deq_pkg::deq_cmd_type                 cmd,
   input  wire logic [deq_pkg::OP_FIELD_W-1:0]       req_operation,
   input  wire logic [deq_pkg::VALUE_FIELD_W-1:0]    req_push_value,
   input  wire logic [deq_pkg::POS_FIELD_W-1:0]      req_position,
   output logic [deq_pkg::VALUE_FIELD_W-1:0]         rsp_read_value,
   output logic [deq_pkg::COUNT_FIELD_W-1:0]         rsp_count,
   output logic [deq_pkg::STAT_FIELD_W-1:0]          rsp_status
);

   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] ring_mem [CAPACITY];

   // captured item
   op_type                  op_ff;
   logic [DATA_WIDTH-1:0]   word_ff;
   logic [POS_FIELD_W-1:0]  pos_ff;

   // queue state
   logic [ADDR_W-1:0]       front_ff, front_in;
   logic [COUNT_W-1:0]      count_ff, count_in;

   // result
   status_type              status_ff, status_in;
   logic                    use_read_ff, use_read_in;
   logic [DATA_WIDTH-1:0]   mem_q_ff;
   logic [DATA_WIDTH-1:0]   read_value_ff;

   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_addr;

   logic [SUM_W-1:0]        front_ext, count_ext, pos_ext;
   logic [ADDR_W-1:0]       back_slot, last_slot, read_slot, next_front, prev_front;
   logic                    full, empty, out_of_range;

   assign front_ext = SUM_W'(front_ff);
   assign count_ext = SUM_W'(count_ff);
   assign pos_ext   = SUM_W'(pos_ff);

   assign back_slot  = wrap_slot(front_ext + count_ext);
   assign last_slot  = wrap_slot(front_ext + count_ext - SUM_W'(1));
   assign read_slot  = wrap_slot(front_ext + pos_ext);
   assign next_front = wrap_slot(front_ext + SUM_W'(1));
   assign prev_front = (front_ff == '0) ? ADDR_W'(CAPACITY - 1) : front_ff - ADDR_W'(1);

   assign full         = (count_ff == COUNT_W'(CAPACITY));
   assign empty        = (count_ff == '0);
   assign out_of_range = (pos_ext >= count_ext);

   always_comb begin
      mem_we      = 1'b0;
      mem_addr    = front_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      status_in   = STAT_OK;
      use_read_in = 1'b0;
      case (op_ff)
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               mem_we   = cmd.execute;
               mem_addr = back_slot;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               mem_we   = cmd.execute;
               mem_addr = prev_front;
               front_in = prev_front;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               mem_addr    = last_slot;
               use_read_in = 1'b1;
               count_in    = count_ff - COUNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               mem_addr    = front_ff;
               use_read_in = 1'b1;
               front_in    = next_front;
               count_in    = count_ff - COUNT_W'(1);
            end
         end
         OP_READ: begin
            if (out_of_range) begin
               status_in = STAT_RANGE;
            end else begin
               mem_addr    = read_slot;
               use_read_in = 1'b1;
            end
         end
         default: begin
            // unused codes leave the queue untouched
         end
      endcase
   end

   // single-port ring: one address per item, written on a push and read into a register on every item
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= word_ff;
      end
      if (cmd.execute) begin
         mem_q_ff <= ring_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_operation);
         word_ff <= req_push_value[DATA_WIDTH-1:0];
         pos_ff  <= req_position;
      end
      if (cmd.execute) begin
         status_ff   <= status_in;
         use_read_ff <= use_read_in;
      end
      if (cmd.load) begin
         read_value_ff <= use_read_ff ? mem_q_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   assign rsp_read_value = VALUE_FIELD_W'(read_value_ff);
   assign rsp_count      = COUNT_FIELD_W'(count_ff);
   assign rsp_status     = status_ff;

endmodule

`default_nettype wire

/* hdl/double_ended_queue_unit.sv */
// Top level of the double-ended queue: stream ports, sequencer and datapath.
//
//   channel  dir  ports           tdata (low bit up)                 tuser
//   req      in   req_t*          push_value[31:0], position[41:32]  operation[2:0]
//   rsp      out  rsp_t*          read_value[31:0], count[42:32]     status[1:0]
//
// One item at a time, in steps: capture, ring access, read-data register,
// result. rsp_tvalid rises after the accepting edge once the access and load
// states have passed, and holds while rsp_tready stays low; req_tready returns
// in the cycle after the result is taken. The single-port ring memory with its
// registered read sets these steps. Synchronous reset empties the queue at once;
// the ring contents are not cleared and need no clearing pass.
`default_nettype none

module double_ended_queue_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [47:0]  req_tdata,  // push_value[31:0], position[41:32], zero pad
   input  wire logic [2:0]   req_tuser,  // operation[2:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [47:0]       rsp_tdata,  // read_value[31:0], count[42:32], zero pad
   output logic [1:0]        rsp_tuser   // status[1:0]
);

   import deq_pkg::*;

   deq_cmd_type                 cmd;
   logic [VALUE_FIELD_W-1:0]    read_value;
   logic [COUNT_FIELD_W-1:0]    count;
   logic [STAT_FIELD_W-1:0]     status;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   deq_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_tuser),
      .req_push_value (req_tdata[31:0]),
      .req_position   (req_tdata[41:32]),
      .rsp_read_value (read_value),
      .rsp_count      (count),
      .rsp_status     (status)
   );

   assign rsp_tdata = {5'd0, count, read_value};
   assign rsp_tuser = status;

endmodule

`default_nettype wire

/* tb/double_ended_queue_unit_tb.sv */
// Self-checking testbench for the double-ended queue: random and directed items.
module double_ended_queue_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   typedef struct packed {
      logic [31:0] read_value;
      logic [10:0] count;
      status_type  status;
   } deque_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;  // push_value[31:0], position[41:32], zero pad
   logic [2:0]  req_tuser = '0;  // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // read_value[31:0], count[42:32], zero pad
   logic [1:0]  rsp_tuser;       // status[1:0]

   // predictor's copy of the queue
   logic [DATA_WIDTH-1:0] ring_copy [CAPACITY];
   int unsigned           front_copy = 0;
   int unsigned           count_copy = 0;

   deque_result_t pending_results[$];

   int    failures      = 0;
   int    items_sent    = 0;
   int    results_seen  = 0;
   int    status_seen[4] = '{0, 0, 0, 0};
   bit    quiet         = 1'b0;  // no idling on either side
   bit    calm          = 1'b0;  // current window has no idling
   int    cycle_count   = 0;
   int    stall_left    = 0;

   double_ended_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   initial begin
      #3_000_000;
      $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
      $display("CHECK FAILED");
      $finish;
   end

   // applies one operation to the queue copy and returns the expected result
   function automatic deque_result_t deque_apply(logic [2:0] op, logic [31:0] word,
                                                 logic [9:0] pos);
      deque_result_t r;
      int unsigned   slot;
      r.read_value = '0;
      r.status     = STAT_OK;
      case (op)
         OP_PUSH_BACK: begin
            if (count_copy >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               slot = (front_copy + count_copy) % CAPACITY;
               ring_copy[slot] = word[DATA_WIDTH-1:0];
               count_copy++;
            end
         end
         OP_PUSH_FRONT: begin
            if (count_copy >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               front_copy = (front_copy == 0) ? CAPACITY - 1 : front_copy - 1;
               ring_copy[front_copy] = word[DATA_WIDTH-1:0];
               count_copy++;
            end
         end
         OP_POP_BACK: begin
            if (count_copy == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               slot = (front_copy + count_copy - 1) % CAPACITY;
               r.read_value = 32'(ring_copy[slot]);
               count_copy--;
            end
         end
         OP_POP_FRONT: begin
            if (count_copy == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.read_value = 32'(ring_copy[front_copy]);
               front_copy = (front_copy + 1) % CAPACITY;
               count_copy--;
            end
         end
         OP_READ: begin
            if (pos >= count_copy) begin
               r.status = STAT_RANGE;
            end else begin
               r.read_value = 32'(ring_copy[(front_copy + pos) % CAPACITY]);
            end
         end
         default: ;  // unused codes leave the queue alone
      endcase
      r.count = 11'(count_copy);
      return r;
   endfunction

   task automatic send_item(logic [2:0] op, logic [31:0] word, logic [9:0] pos);
      int gap;
      @(negedge clock);
      if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {6'd0, pos, word};
      req_tuser  = op;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(deque_apply(op, word, pos));
      items_sent++;
   endtask

   // receiver stalls in bursts; a random draw per window decides whether idling is allowed
   always @(negedge clock) begin
      cycle_count++;
      if (cycle_count % 200 == 0)
         calm = ($urandom_range(0, 2) == 0);
      if (quiet || calm) begin
         stall_left = 0;
         rsp_tready = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      deque_result_t got;
      deque_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value = rsp_tdata[31:0];
         got.count      = rsp_tdata[42:32];
         got.status     = status_type'(rsp_tuser);
         results_seen++;
         status_seen[got.status]++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, %s %h count %0d status %0d",
                     $time, "actual value", got.read_value, got.count, got.status);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch: expected value %h count %0d status %0d,",
                        $time, want.read_value, want.count, want.status);
               $display("%0t:           actual value %h count %0d status %0d",
                        $time, got.read_value, got.count, got.status);
               failures++;
            end
         end
      end
   end

   task automatic test_empty_queue();
      send_item(OP_POP_BACK, 32'hFFFF_FFFF, 10'h3FF);
      send_item(OP_POP_FRONT, 32'h1234_5678, 10'd0);
      send_item(OP_READ, 32'h0, 10'd0);
      send_item(OP_READ, 32'h0, 10'h3FF);
   endtask

   task automatic test_basic_ops();
      send_item(OP_PUSH_BACK, 32'hFFFF_FFFF, 10'h3FF);
      send_item(OP_PUSH_FRONT, 32'h0000_0000, 10'd0);
      send_item(OP_PUSH_BACK, 32'hA5A5_5A5A, 10'h155);
      send_item(OP_READ, 32'hFFFF_FFFF, 10'd0);
      send_item(OP_READ, 32'h0, 10'd1);
      send_item(OP_READ, 32'h0, 10'd2);
      send_item(OP_READ, 32'h0, 10'd3);  // just past the count
      send_item(OP_POP_FRONT, 32'h0, 10'd0);
      send_item(OP_POP_BACK, 32'h0, 10'd0);
      send_item(OP_READ, 32'h0, 10'd0);
      send_item(3'd5, 32'hDEAD_BEEF, 10'h2AA);
      send_item(3'd6, 32'hFFFF_FFFF, 10'h3FF);
      send_item(3'd7, 32'h0, 10'd0);
      send_item(OP_POP_BACK, 32'h0, 10'd0);
      send_item(OP_POP_BACK, 32'h0, 10'd0);
   endtask

   task automatic test_random_traffic(int n);
      int         push_pct;
      int         r;
      logic [2:0] op;
      logic [9:0] pos;
      push_pct = 50;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0)
            push_pct = $urandom_range(20, 80);  // let the count drift up and down
         r = $urandom_range(0, 99);
         if (r < 2)
            op = 3'($urandom_range(5, 7));
         else if (r < 20)
            op = OP_READ;
         else if ($urandom_range(0, 99) < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
         if (count_copy > 0 && $urandom_range(0, 3) != 0)
            pos = 10'($urandom_range(0, count_copy - 1));
         else
            pos = 10'($urandom());
         send_item(op, $urandom(), pos);
      end
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_basic_ops();
      test_random_traffic(530);
      quiet = 1'b1;
      test_random_traffic(100);

      @(negedge clock);
      req_tvalid = 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
         failures += pending_results.size();
      end

      $display("Sent %0d items: pushes at both ends, pops, reads in and past range, unused codes.",
               items_sent);
      $display("Checked %0d results: %0d ok, %0d empty, %0d full, %0d out of range; %0d failures.",
               results_seen, status_seen[STAT_OK], status_seen[STAT_EMPTY],
               status_seen[STAT_FULL], status_seen[STAT_RANGE], failures);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_dpath.sv
hdl/double_ended_queue_unit.sv
tb/double_ended_queue_unit_tb.sv
